// File: rtl/rcpd_pkg.sv
// Shared types and constants for the RC PWM command decoder.
`default_nettype none

package rcpd_pkg;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned US_W      = 16;
  localparam int unsigned TO_W      = 16;
  localparam int unsigned MUL_W     = 20;
  localparam int unsigned PROD_W    = TIME_W + MUL_W;
  localparam int unsigned DIV_CNT_W = $clog2(PROD_W);
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [MUL_W-1:0] US_PER_S = MUL_W'(1000000);

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // reset values of the configuration registers
  localparam logic [TIME_W-1:0] RES_HZ_RST       = '0;
  localparam logic [US_W-1:0]   LOW_MAX_RST      = US_W'(1200);
  localparam logic [US_W-1:0]   HIGH_MIN_RST     = US_W'(1500);
  localparam logic [US_W-1:0]   VALID_MIN_RST    = US_W'(800);
  localparam logic [US_W-1:0]   VALID_MAX_RST    = US_W'(2200);
  localparam logic [TO_W-1:0]   LOSS_TIMEOUT_RST = TO_W'(500);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RES_HZ       = 3'd0,
    REG_LOW_MAX      = 3'd1,
    REG_HIGH_MIN     = 3'd2,
    REG_VALID_MIN    = 3'd3,
    REG_VALID_MAX    = 3'd4,
    REG_LOSS_TIMEOUT = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    EV_PUMP_ON        = 3'd0,
    EV_PUMP_OFF       = 3'd1,
    EV_NOZZLE_RETRACT = 3'd2,
    EV_NOZZLE_EXTEND  = 3'd3,
    EV_SIGNAL_LOST    = 3'd4
  } event_code_t;

  typedef enum logic [1:0] {
    LVL_UNKNOWN = 2'd0,
    LVL_LOW     = 2'd1,
    LVL_HIGH    = 2'd2
  } level_t;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_RISE = 2'd1,
    KIND_FALL = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV
  } back_state_t;

  // one classified word in the queue
  typedef struct packed {
    kind_t             kind;
    logic              ch;
    logic [TIME_W-1:0] value;
  } edge_item_t;

  typedef struct packed {
    logic [TIME_W-1:0] res_hz;
    logic [US_W-1:0]   low_max;
    logic [US_W-1:0]   high_min;
    logic [US_W-1:0]   valid_min;
    logic [US_W-1:0]   valid_max;
    logic [TO_W-1:0]   loss_timeout;
  } cfg_t;

  // queue status seen by the front and back
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

`default_nettype wire

// File: rtl/rcpd_front.sv
// Front end: takes input words, classifies them and drops ignored captures.
`default_nettype none

module rcpd_front import rcpd_pkg::*; (
  input  wire logic              action,
  input  wire logic              channel,
  input  wire logic              edge_falling,
  input  wire logic [TIME_W-1:0] capture_value,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire logic [TIME_W-1:0] res_hz,
  input  wire queue_status_t     q_status,
  output logic                   push,
  output edge_item_t             push_item
);

  logic keep;

  // captures mean nothing while the tick rate is unset
  assign keep       = action || (res_hz != '0);
  assign item_stall = q_status.full;
  assign push       = item_valid && !q_status.full && keep;

  always_comb begin
    push_item.ch    = channel;
    push_item.value = capture_value;
    unique case ({action, edge_falling})
      2'b00:          push_item.kind = KIND_RISE;
      2'b01:          push_item.kind = KIND_FALL;
      default:        push_item.kind = KIND_TICK;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rcpd_fifo.sv
// Short word queue between the front and back ends.
`default_nettype none

module rcpd_fifo import rcpd_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire edge_item_t push_item,
  input  wire logic       pop,
  output edge_item_t      head,
  output queue_status_t   status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  edge_item_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign status.empty = (count == '0);
  assign status.full  = (count == CNT_W'(DEPTH));
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !status.full || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !status.empty)
    else $error("queue pop while empty");

  a_ptr_match: assert property (@(posedge clk) disable iff (rst)
    (status.empty || status.full) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// File: rtl/rcpd_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module rcpd_div import rcpd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [TIME_W-1:0] divisor,
  output logic                   done,
  output logic [PROD_W-1:0]      quotient
);

  logic [TIME_W-1:0]    rem;
  logic [PROD_W-1:0]    dq;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 running;
  logic [TIME_W:0]      rem_sh, diff;
  logic                 ge;

  assign rem_sh   = {rem, dq[PROD_W-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign diff     = rem_sh - {1'b0, divisor};
  assign quotient = dq;

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dq  <= dividend;
      cnt <= '0;
    end else if (running) begin
      rem <= ge ? diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
      dq  <= {dq[PROD_W-2:0], ge};
      cnt <= cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
      end else if (running && cnt == DIV_CNT_W'(PROD_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/rcpd_back.sv
// Back end: edge timing, width conversion, classification and loss timeout.
`default_nettype none

module rcpd_back import rcpd_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire cfg_t          cfg,
  input  wire edge_item_t    head,
  input  wire queue_status_t q_status,
  output logic               pop,
  output logic               result_valid,
  input  wire logic          result_stall,
  output logic [2:0]         event_code,
  output logic [US_W-1:0]    pulse_width_us
);

  back_state_t          state, state_next;
  logic [TIME_W-1:0]    rise_time [2];
  logic [TIME_W-1:0]    rise_time_next [2];
  logic [1:0]           rise_seen, rise_seen_next;
  level_t               level [2];
  level_t               level_next [2];
  logic [TO_W-1:0]      tcount, tcount_next;
  logic                 armed, armed_next;
  logic                 lost, lost_next;
  logic                 cur_ch, cur_ch_next;
  logic [TIME_W-1:0]    ticks, ticks_next;
  logic [PROD_W-1:0]    prod, prod_next;
  logic                 res_valid, res_valid_next;
  event_code_t          res_code, res_code_next;
  logic [US_W-1:0]      res_width, res_width_next;

  logic                 div_start, div_done;
  logic [PROD_W-1:0]    quot;
  logic                 out_free, lost_load;
  logic [TO_W-1:0]      tcount_inc;
  logic                 us_over, us_valid;
  logic [US_W-1:0]      us;
  level_t               new_level;

  rcpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (cfg.res_hz),
    .done     (div_done),
    .quotient (quot)
  );

  assign out_free   = !res_valid || !result_stall;
  assign tcount_inc = tcount + TO_W'(1);
  assign us_over    = |quot[PROD_W-1:US_W];
  assign us         = quot[US_W-1:0];
  assign us_valid   = !us_over && (us >= cfg.valid_min) && (us <= cfg.valid_max);

  always_comb begin
    if (us <= cfg.low_max)       new_level = LVL_LOW;
    else if (us >= cfg.high_min) new_level = LVL_HIGH;
    else                         new_level = LVL_UNKNOWN;
  end

  always_comb begin
    state_next     = state;
    rise_time_next = rise_time;
    rise_seen_next = rise_seen;
    level_next     = level;
    tcount_next    = tcount;
    armed_next     = armed;
    lost_next      = lost;
    cur_ch_next    = cur_ch;
    ticks_next     = ticks;
    prod_next      = prod;
    res_valid_next = res_valid && result_stall;
    res_code_next  = res_code;
    res_width_next = res_width;
    pop            = 1'b0;
    div_start      = 1'b0;
    lost_load      = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (!q_status.empty && out_free) begin
          pop = 1'b1;
          unique case (head.kind)
            KIND_TICK: begin
              if (armed) begin
                if (tcount_inc < cfg.loss_timeout) begin
                  tcount_next = tcount_inc;
                end else begin
                  armed_next  = 1'b0;
                  tcount_next = '0;
                  if (!lost) begin
                    lost_next      = 1'b1;
                    level_next[0]  = LVL_UNKNOWN;
                    level_next[1]  = LVL_UNKNOWN;
                    rise_seen_next = '0;
                    res_valid_next = 1'b1;
                    res_code_next  = EV_SIGNAL_LOST;
                    res_width_next = '0;
                    lost_load      = 1'b1;
                  end
                end
              end
            end
            KIND_RISE: begin
              rise_time_next[head.ch] = head.value;
              rise_seen_next[head.ch] = 1'b1;
            end
            KIND_FALL: begin
              if (rise_seen[head.ch]) begin
                rise_seen_next[head.ch] = 1'b0;
                ticks_next  = head.value - rise_time[head.ch];
                cur_ch_next = head.ch;
                state_next  = ST_MUL;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MUL: begin
        prod_next  = PROD_W'(ticks) * PROD_W'(US_PER_S);
        state_next = ST_START;
      end
      ST_START: begin
        div_start  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_IDLE;
          if (us_valid) begin
            tcount_next = '0;
            armed_next  = 1'b1;
            lost_next   = 1'b0;
            if (new_level != LVL_UNKNOWN && new_level != level[cur_ch]) begin
              level_next[cur_ch] = new_level;
              res_valid_next     = 1'b1;
              res_width_next     = us;
              if (!cur_ch) begin
                res_code_next = (new_level == LVL_LOW) ? EV_PUMP_ON : EV_PUMP_OFF;
              end else begin
                res_code_next = (new_level == LVL_LOW) ? EV_NOZZLE_RETRACT
                                                       : EV_NOZZLE_EXTEND;
              end
            end
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      rise_time[0] <= '0;
      rise_time[1] <= '0;
      rise_seen    <= '0;
      level[0]     <= LVL_UNKNOWN;
      level[1]     <= LVL_UNKNOWN;
      tcount       <= '0;
      armed        <= 1'b1;
      lost         <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      state     <= state_next;
      rise_time <= rise_time_next;
      rise_seen <= rise_seen_next;
      level     <= level_next;
      tcount    <= tcount_next;
      armed     <= armed_next;
      lost      <= lost_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur_ch    <= cur_ch_next;
    ticks     <= ticks_next;
    prod      <= prod_next;
    res_code  <= res_code_next;
    res_width <= res_width_next;
  end

  assign result_valid   = res_valid;
  assign event_code     = res_code;
  assign pulse_width_us = res_width;

  a_pop_idle_only: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE) && out_free)
    else $error("queue popped while a capture is in flight");

  a_lost_sets_flag: assert property (@(posedge clk) disable iff (rst)
    lost_load |=> lost && !armed && (level[0] == LVL_UNKNOWN) && (rise_seen == 2'b00))
    else $error("signal-lost word without loss state");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the wait state");

  a_lost_zero_width: assert property (@(posedge clk) disable iff (rst)
    (result_valid && res_code == EV_SIGNAL_LOST) |-> (res_width == '0))
    else $error("signal-lost word carries a width");

endmodule

`default_nettype wire

// File: rtl/rc_pwm_command_decoder.sv
// Top level: two-channel RC PWM pulse decoder with config registers.
// The back end pops a word once it heads the queue and the output is free; a tick
//   that declares loss loads its result word on the same edge as its pop.
// A falling edge gives its command word after pop, multiply, divider start, a
//   bit-serial divide by the capture resolution (shared divider), result load.
// Ticks and rising edges go one per cycle while the back end is idle and the output
//   free; a falling edge holds later ones until done. A 4-word queue absorbs bursts.
// Reset (synchronous, rst high): registers to defaults, queue empty, timer armed.
`default_nettype none

module rc_pwm_command_decoder import rcpd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // capture / tick words
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire logic                 action,
  input  wire logic                 channel,
  input  wire logic                 edge_falling,
  input  wire logic [TIME_W-1:0]    capture_value,
  // command words
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output logic [2:0]                event_code,
  output logic [US_W-1:0]           pulse_width_us,
  // register writes
  input  wire logic                 wr_en,
  input  wire logic [CFG_IDX_W-1:0] wr_index,
  input  wire logic [CFG_DAT_W-1:0] wr_data
);

  cfg_t          cfg;
  logic          push, pop;
  edge_item_t    push_item, head;
  queue_status_t q_status;

  // Config registers; writes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.res_hz       <= RES_HZ_RST;
      cfg.low_max      <= LOW_MAX_RST;
      cfg.high_min     <= HIGH_MIN_RST;
      cfg.valid_min    <= VALID_MIN_RST;
      cfg.valid_max    <= VALID_MAX_RST;
      cfg.loss_timeout <= LOSS_TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_RES_HZ:       cfg.res_hz       <= wr_data[TIME_W-1:0];
        REG_LOW_MAX:      cfg.low_max      <= wr_data[US_W-1:0];
        REG_HIGH_MIN:     cfg.high_min     <= wr_data[US_W-1:0];
        REG_VALID_MIN:    cfg.valid_min    <= wr_data[US_W-1:0];
        REG_VALID_MAX:    cfg.valid_max    <= wr_data[US_W-1:0];
        REG_LOSS_TIMEOUT: cfg.loss_timeout <= wr_data[TO_W-1:0];
        default: ;
      endcase
    end
  end

  // Front: classify the word, drop captures while the resolution is zero.
  rcpd_front u_front (
    .action        (action),
    .channel       (channel),
    .edge_falling  (edge_falling),
    .capture_value (capture_value),
    .item_valid    (item_valid),
    .item_stall    (item_stall),
    .res_hz        (cfg.res_hz),
    .q_status      (q_status),
    .push          (push),
    .push_item     (push_item)
  );

  // Decoupling queue; back end drains it in order.
  rcpd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // Back: width measurement, us conversion, level tracking, loss timeout.
  rcpd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .head           (head),
    .q_status       (q_status),
    .pop            (pop),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .event_code     (event_code),
    .pulse_width_us (pulse_width_us)
  );

endmodule

`default_nettype wire

// File: sim/tb_rc_pwm_command_decoder.sv
// Self-checking testbench for the two-channel RC PWM command decoder.
`default_nettype none

module tb_rc_pwm_command_decoder;
  import rcpd_pkg::*;

  // Run shape. SETTLE_CYCLES covers a full input queue of falling edges still
  // working through the divider after the last command word has come out.
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned SETTLE_CYCLES  = 400;
  localparam int unsigned HOLD_CYCLES    = 1500;
  localparam int unsigned WATCHDOG_LIMIT = 10000;
  localparam int unsigned WORDS_TARGET   = 1300;
  localparam int unsigned PHASE_WORDS    = 100;
  localparam int unsigned IDLE_PCT       = 36;
  localparam int          NO_IDLE_PHASE  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);
  localparam logic [63:0] US_PER_SECOND = 64'd1000000;

  // input word codes
  localparam logic ACT_EDGE  = 1'b0;
  localparam logic ACT_TICK  = 1'b1;
  localparam logic EDGE_RISE = 1'b0;
  localparam logic EDGE_FALL = 1'b1;
  localparam logic CH_PUMP   = 1'b0;
  localparam logic CH_NOZZLE = 1'b1;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  // one row of the directed table; value doubles as register data
  typedef struct packed {
    row_kind_t            kind;
    logic                 act;
    logic                 ch;
    logic                 fall;
    logic [TIME_W-1:0]    value;
    logic [CFG_IDX_W-1:0] idx;
    logic                 typed;
    logic                 has_cmd;
    event_code_t          code;
    logic [US_W-1:0]      width;
  } stim_row_t;

  typedef struct packed {
    event_code_t     code;
    logic [US_W-1:0] width;
  } cmd_word_t;

  // ---------------------------------------------------------------- DUT I/O
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 item_valid = 1'b0;
  logic                 item_stall;
  logic                 action = 1'b0;
  logic                 channel = 1'b0;
  logic                 edge_falling = 1'b0;
  logic [TIME_W-1:0]    capture_value = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  logic [2:0]           event_code;
  logic [US_W-1:0]      pulse_width_us;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [CFG_DAT_W-1:0] wr_data = '0;

  rc_pwm_command_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .action         (action),
    .channel        (channel),
    .edge_falling   (edge_falling),
    .capture_value  (capture_value),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .event_code     (event_code),
    .pulse_width_us (pulse_width_us),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------- run control
  logic        tx_idle_en = 1'b1;   // main process only
  logic        rx_idle_en = 1'b1;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;    // sink process only
  int unsigned n_words = 0;
  int unsigned n_cmds = 0;
  int unsigned n_errors = 0;
  int unsigned quiet = 0;

  cmd_word_t cmds_due[$];

  // ------------------------------------------- decoder copy (predictor)
  logic [TIME_W-1:0] cfg_res_hz    = RES_HZ_RST;
  logic [US_W-1:0]   cfg_low_max   = LOW_MAX_RST;
  logic [US_W-1:0]   cfg_high_min  = HIGH_MIN_RST;
  logic [US_W-1:0]   cfg_valid_min = VALID_MIN_RST;
  logic [US_W-1:0]   cfg_valid_max = VALID_MAX_RST;
  logic [TO_W-1:0]   cfg_loss      = LOSS_TIMEOUT_RST;

  logic [TIME_W-1:0] rise_at [2];
  logic              rise_armed [2];
  level_t            lvl_now [2];
  logic [TO_W-1:0]   idle_ticks = '0;
  logic              timer_run = 1'b1;
  logic              sig_lost = 1'b0;

  // Works out the command word, if any, that one accepted word causes.
  function automatic logic decode_word(input logic act, input logic ch, input logic fall,
                                       input logic [TIME_W-1:0] val,
                                       output cmd_word_t cmd);
    logic [TIME_W-1:0] span;
    logic [63:0]       us;
    level_t            lvl;
    cmd.code  = EV_SIGNAL_LOST;
    cmd.width = '0;
    if (act == ACT_TICK) begin
      // one-shot loss timer: a zero limit expires on the first tick
      if (!timer_run) return 1'b0;
      idle_ticks = idle_ticks + TO_W'(1);
      if (idle_ticks < cfg_loss) return 1'b0;
      timer_run  = 1'b0;
      idle_ticks = '0;
      if (sig_lost) return 1'b0;
      sig_lost = 1'b1;
      for (int c = 0; c < 2; c++) begin
        lvl_now[c]    = LVL_UNKNOWN;
        rise_armed[c] = 1'b0;
      end
      return 1'b1;
    end
    if (cfg_res_hz == '0) return 1'b0;
    if (fall == EDGE_RISE) begin
      rise_at[ch]    = val;
      rise_armed[ch] = 1'b1;
      return 1'b0;
    end
    if (!rise_armed[ch]) return 1'b0;
    span = val - rise_at[ch];               // wraps modulo 2^32
    us   = (64'(span) * US_PER_SECOND) / 64'(cfg_res_hz);
    rise_armed[ch] = 1'b0;
    if (us < 64'(cfg_valid_min) || us > 64'(cfg_valid_max)) return 1'b0;
    idle_ticks = '0;
    timer_run  = 1'b1;
    sig_lost   = 1'b0;
    // low test first, so overlapping thresholds read as low
    if (us <= 64'(cfg_low_max)) lvl = LVL_LOW;
    else if (us >= 64'(cfg_high_min)) lvl = LVL_HIGH;
    else return 1'b0;
    if (lvl == lvl_now[ch]) return 1'b0;
    lvl_now[ch] = lvl;
    if (ch == CH_PUMP) begin
      if (lvl == LVL_LOW) cmd.code = EV_PUMP_ON;
      else cmd.code = EV_PUMP_OFF;
    end else begin
      if (lvl == LVL_LOW) cmd.code = EV_NOZZLE_RETRACT;
      else cmd.code = EV_NOZZLE_EXTEND;
    end
    cmd.width = us[US_W-1:0];
    return 1'b1;
  endfunction

  // ------------------------------------------------- directed table rows
  function automatic stim_row_t word_row(input logic act, input logic ch, input logic fall,
                                         input logic [TIME_W-1:0] val);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_WORD;
    r.act   = act;
    r.ch    = ch;
    r.fall  = fall;
    r.value = val;
    r.code  = EV_PUMP_ON;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic act, input logic ch, input logic fall,
                                          input logic [TIME_W-1:0] val, input logic has,
                                          input event_code_t code, input logic [US_W-1:0] w);
    stim_row_t r;
    r         = word_row(act, ch, fall, val);
    r.typed   = 1'b1;
    r.has_cmd = has;
    r.code    = code;
    r.width   = w;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DAT_W-1:0] data);
    stim_row_t r;
    r       = '0;
    r.kind  = ROW_REG;
    r.idx   = idx;
    r.value = data;
    r.code  = EV_PUMP_ON;
    return r;
  endfunction

  // ---------------------------------------------------------- drivers
  // Offers one word and returns in the step of the edge that took it.
  // Gaps are chosen before valid rises, so valid never follows stall.
  task automatic send_word(input logic act, input logic ch, input logic fall,
                           input logic [TIME_W-1:0] val);
    if (tx_idle_en) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_valid    <= 1'b1;
    action        <= act;
    channel       <= ch;
    edge_falling  <= fall;
    capture_value <= val;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic offer(input logic act, input logic ch, input logic fall,
                       input logic [TIME_W-1:0] val);
    cmd_word_t cmd;
    send_word(act, ch, fall, val);
    if (decode_word(act, ch, fall, val, cmd)) begin
      cmds_due.push_back(cmd);
      n_cmds++;
    end
    n_words++;
  endtask

  // Leaves the decoder idle: all commands out, divider finished.
  task automatic settle();
    item_valid <= 1'b0;
    while (cmds_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DAT_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    case (idx)
      REG_RES_HZ:       cfg_res_hz    = data;
      REG_LOW_MAX:      cfg_low_max   = data[US_W-1:0];
      REG_HIGH_MIN:     cfg_high_min  = data[US_W-1:0];
      REG_VALID_MIN:    cfg_valid_min = data[US_W-1:0];
      REG_VALID_MAX:    cfg_valid_max = data[US_W-1:0];
      REG_LOSS_TIMEOUT: cfg_loss      = data[TO_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // One setting per random phase. The first few phases pin the extremes;
  // upper data bits of the 16-bit registers are junk to exercise masking.
  task automatic program_setting(input int ph);
    logic [TIME_W-1:0] res;
    logic [US_W-1:0]   lo, hi, vmin, vmax, loss;
    if (ph == 0) res = '1;
    else if (ph == 1) res = TIME_W'(1);
    else if (ph == 2) res = '0;
    else begin
      case ($urandom_range(3))
        0:       res = TIME_W'(US_PER_SECOND);
        1:       res = TIME_W'(8000000);
        default: res = $urandom_range(40000000, 100000);
      endcase
    end
    if (ph == 3) begin
      lo = '0; hi = '0; vmin = '0; vmax = '1;
    end else if (ph == 4) begin
      lo = '1; hi = '1; vmin = '0; vmax = '1;
    end else begin
      vmin = US_W'($urandom_range(900, 600));
      vmax = US_W'($urandom_range(2500, 1900));
      lo   = US_W'($urandom_range(1400, 1000));
      hi   = US_W'($urandom_range(1700, 1150));  // may overlap the low band
    end
    if (ph == 5) loss = '1;
    else if (ph == 6) loss = TO_W'(1);
    else if (ph == 7) loss = '0;
    else loss = TO_W'($urandom_range(20, 2));
    write_reg(REG_RES_HZ, res);
    write_reg(REG_LOW_MAX, {16'($urandom()), lo});
    write_reg(REG_HIGH_MIN, {16'($urandom()), hi});
    write_reg(REG_VALID_MIN, {16'($urandom()), vmin});
    write_reg(REG_VALID_MAX, {16'($urandom()), vmax});
    write_reg(REG_LOSS_TIMEOUT, {16'($urandom()), loss});
    if (ph % 4 == 1) write_reg(REG_UNUSED, $urandom());
  endtask

  // Rise then fall on one channel, width aimed at a threshold or at random.
  task automatic send_pulse();
    logic              ch;
    logic [TIME_W-1:0] t0;
    logic [63:0]       span;
    int                tgt;
    ch = 1'($urandom());
    case ($urandom_range(5))
      0:       tgt = int'(cfg_valid_min);
      1:       tgt = int'(cfg_valid_max);
      2:       tgt = int'(cfg_low_max);
      3:       tgt = int'(cfg_high_min);
      4:       tgt = $urandom_range(2400, 600);
      default: tgt = $urandom_range(65535);
    endcase
    if ($urandom_range(3) != 0) tgt = tgt + int'($urandom_range(6)) - 3;
    if (tgt < 0) tgt = 0;
    // random fraction so the tick count rounds either side of the target
    span = (64'(tgt) * 64'(cfg_res_hz) + 64'($urandom_range(999999))) / US_PER_SECOND;
    t0   = $urandom();
    offer(ACT_EDGE, ch, EDGE_RISE, t0);
    if ($urandom_range(9) == 0) offer(ACT_TICK, 1'($urandom()), 1'($urandom()), $urandom());
    if ($urandom_range(9) == 0) offer(ACT_EDGE, ~ch, EDGE_RISE, $urandom());
    offer(ACT_EDGE, ch, EDGE_FALL, t0 + span[TIME_W-1:0]);
  endtask

  // ---------------------------------------------------- command sink
  // Random stalls, none during the quiet phase, and one long hold-off
  // on request so the input queue fills and stalls the sender.
  initial begin : result_sink
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (rx_idle_en) begin
        result_stall <= ($urandom_range(99) < IDLE_PCT);
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------- checker
  always @(posedge clk) begin
    cmd_word_t due;
    if (!rst && result_valid && !result_stall) begin
      if (cmds_due.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected command word: expected none, got code %0d width %0d",
                 $time, event_code, pulse_width_us);
      end else begin
        due = cmds_due.pop_front();
        if (event_code !== due.code) begin
          n_errors++;
          $display("%0t: event_code expected %0d got %0d", $time, due.code, event_code);
        end
        if (pulse_width_us !== due.width) begin
          n_errors++;
          $display("%0t: pulse_width_us expected %0d got %0d",
                   $time, due.width, pulse_width_us);
        end
      end
    end
  end

  // ------------------------------------------------------ watchdog
  // Counts cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no word moved for %0d cycles", $time, quiet);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ------------------------------------------------------ stimulus
  initial begin : stimulus
    stim_row_t         rows[$];
    cmd_word_t         cmd;
    logic              got;
    logic [TIME_W-1:0] t0;
    logic [US_W-1:0]   w;
    int                ph;
    int unsigned       phase_end, pick;

    for (int c = 0; c < 2; c++) begin
      rise_at[c]    = '0;
      rise_armed[c] = 1'b0;
      lvl_now[c]    = LVL_UNKNOWN;
    end

    // Directed table. Straight after reset the resolution is zero, so the
    // rise is dropped and the later fall has nothing to pair with.
    rows.push_back(typed_row(ACT_EDGE, CH_PUMP, EDGE_RISE, 32'd100, 1'b0, EV_PUMP_ON, 16'd0));
    rows.push_back(reg_row(REG_RES_HZ, CFG_DAT_W'(US_PER_SECOND)));   // 1 tick = 1 us
    rows.push_back(typed_row(ACT_EDGE, CH_PUMP, EDGE_FALL, 32'd1300, 1'b0, EV_PUMP_ON, 16'd0));
    // second rise overwrites the first; the fall wraps past 2^32
    rows.push_back(word_row(ACT_EDGE, CH_PUMP, EDGE_RISE, 32'hFFFF_FF00));
    rows.push_back(word_row(ACT_EDGE, CH_PUMP, EDGE_RISE, 32'hFFFF_FFF0));
    rows.push_back(typed_row(ACT_EDGE, CH_PUMP, EDGE_FALL, 32'h0000_03A0,
                             1'b1, EV_PUMP_ON, 16'd944));
    // same level again
    rows.push_back(word_row(ACT_EDGE, CH_PUMP, EDGE_RISE, 32'd1000));
    rows.push_back(word_row(ACT_EDGE, CH_PUMP, EDGE_FALL, 32'd2000));
    // top of the valid window
    rows.push_back(word_row(ACT_EDGE, CH_PUMP, EDGE_RISE, 32'd0));
    rows.push_back(typed_row(ACT_EDGE, CH_PUMP, EDGE_FALL, 32'd2200,
                             1'b1, EV_PUMP_OFF, 16'd2200));
    // just outside the window on both sides, then its bottom edge
    rows.push_back(word_row(ACT_EDGE, CH_NOZZLE, EDGE_RISE, 32'd0));
    rows.push_back(typed_row(ACT_EDGE, CH_NOZZLE, EDGE_FALL, 32'd2201,
                             1'b0, EV_PUMP_ON, 16'd0));
    rows.push_back(word_row(ACT_EDGE, CH_NOZZLE, EDGE_RISE, 32'd0));
    rows.push_back(typed_row(ACT_EDGE, CH_NOZZLE, EDGE_FALL, 32'd799,
                             1'b0, EV_PUMP_ON, 16'd0));
    rows.push_back(word_row(ACT_EDGE, CH_NOZZLE, EDGE_RISE, 32'd0));
    rows.push_back(typed_row(ACT_EDGE, CH_NOZZLE, EDGE_FALL, 32'd800,
                             1'b1, EV_NOZZLE_RETRACT, 16'd800));
    // deadband: timer restarted, no command
    rows.push_back(word_row(ACT_EDGE, CH_NOZZLE, EDGE_RISE, 32'd10));
    rows.push_back(word_row(ACT_EDGE, CH_NOZZLE, EDGE_FALL, 32'd1360));
    rows.push_back(word_row(ACT_EDGE, CH_NOZZLE, EDGE_RISE, 32'd0));
    rows.push_back(typed_row(ACT_EDGE, CH_NOZZLE, EDGE_FALL, 32'd1500,
                             1'b1, EV_NOZZLE_EXTEND, 16'd1500));
    // loss after two ticks; a further tick finds the timer stopped
    rows.push_back(reg_row(REG_LOSS_TIMEOUT, CFG_DAT_W'(2)));
    rows.push_back(word_row(ACT_TICK, CH_NOZZLE, EDGE_FALL, 32'hFFFF_FFFF));
    rows.push_back(typed_row(ACT_TICK, CH_PUMP, EDGE_RISE, 32'd0,
                             1'b1, EV_SIGNAL_LOST, 16'd0));
    rows.push_back(typed_row(ACT_TICK, CH_PUMP, EDGE_RISE, 32'd0,
                             1'b0, EV_PUMP_ON, 16'd0));
    // zero timeout, overlapping thresholds, write to an unused index
    rows.push_back(reg_row(REG_LOSS_TIMEOUT, 32'hABCD_0000));
    rows.push_back(reg_row(REG_LOW_MAX, CFG_DAT_W'(1600)));
    rows.push_back(reg_row(REG_HIGH_MIN, CFG_DAT_W'(1000)));
    rows.push_back(reg_row(REG_UNUSED, 32'h5A5A_5A5A));
    rows.push_back(word_row(ACT_EDGE, CH_PUMP, EDGE_RISE, 32'h1234_5678));
    rows.push_back(typed_row(ACT_EDGE, CH_PUMP, EDGE_FALL, 32'h1234_5B8C,
                             1'b1, EV_PUMP_ON, 16'd1300));
    rows.push_back(typed_row(ACT_TICK, CH_NOZZLE, EDGE_FALL, 32'h8000_0001,
                             1'b1, EV_SIGNAL_LOST, 16'd0));

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the table. The predictor sees every word so its state stays in
    // step; typed rows supply their own expectation.
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        if (i > 0 && rows[i-1].kind == ROW_WORD) settle();
        write_reg(rows[i].idx, rows[i].value);
      end else begin
        send_word(rows[i].act, rows[i].ch, rows[i].fall, rows[i].value);
        got = decode_word(rows[i].act, rows[i].ch, rows[i].fall, rows[i].value, cmd);
        if (rows[i].typed) begin
          got       = rows[i].has_cmd;
          cmd.code  = rows[i].code;
          cmd.width = rows[i].width;
        end
        if (got) begin
          cmds_due.push_back(cmd);
          n_cmds++;
        end
        n_words++;
      end
    end

    // Back-pressure: the sink holds off while pulses of alternating level
    // keep coming with no gaps, so every one yields a command word.
    settle();
    write_reg(REG_RES_HZ, CFG_DAT_W'(US_PER_SECOND));
    write_reg(REG_LOW_MAX, CFG_DAT_W'(LOW_MAX_RST));
    write_reg(REG_HIGH_MIN, CFG_DAT_W'(HIGH_MIN_RST));
    write_reg(REG_VALID_MIN, CFG_DAT_W'(VALID_MIN_RST));
    write_reg(REG_VALID_MAX, CFG_DAT_W'(VALID_MAX_RST));
    write_reg(REG_LOSS_TIMEOUT, CFG_DAT_W'(16'hFFFF));
    tx_idle_en = 1'b0;
    hold_go <= 1'b1;
    for (int k = 0; k < 24; k++) begin
      t0 = $urandom();
      if (k[1]) w = 16'($urandom_range(2200, 1500));
      else w = 16'($urandom_range(1200, 800));
      offer(ACT_EDGE, k[0], EDGE_RISE, t0);
      offer(ACT_EDGE, k[0], EDGE_FALL, t0 + TIME_W'(w));
    end
    tx_idle_en = 1'b1;

    // Random phases: mostly well-formed pulses, plus ticks and stray edges.
    ph = 0;
    while (n_words < WORDS_TARGET) begin
      settle();
      program_setting(ph);
      tx_idle_en = (ph != NO_IDLE_PHASE);
      rx_idle_en <= (ph != NO_IDLE_PHASE);
      phase_end = n_words + PHASE_WORDS;
      while (n_words < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 55) send_pulse();
        else if (pick < 85) offer(ACT_TICK, 1'($urandom()), 1'($urandom()), $urandom());
        else offer(ACT_EDGE, 1'($urandom()), 1'($urandom()), $urandom());
      end
      ph++;
    end

    settle();
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/rcpd_pkg.sv
rtl/rcpd_front.sv
rtl/rcpd_fifo.sv
rtl/rcpd_div.sv
rtl/rcpd_back.sv
rtl/rc_pwm_command_decoder.sv
sim/tb_rc_pwm_command_decoder.sv
